>>> design/bss_pkg.sv
// Shared types, piece codes and the slab corner helper for the box subtract split block.
`default_nettype none

package bss_pkg;

    typedef logic [7:0] coord_t;

    // Decoded bounds of one box, index 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } bounds_t;

    // Stored form of a box: first corner and the inverted far corner.
    typedef struct packed {
        logic [23:0] first;
        logic [23:0] second;
    } corners_t;

    typedef enum logic [2:0] {
        KIND_LEFT   = 3'd0,
        KIND_BELOW  = 3'd1,
        KIND_BEHIND = 3'd2,
        KIND_RIGHT  = 3'd3,
        KIND_ABOVE  = 3'd4,
        KIND_FRONT  = 3'd5,
        KIND_INNER  = 3'd6
    } piece_kind_t;

    localparam int unsigned NUM_KINDS = 7;
    localparam coord_t BYTE_MAX = 8'hFF;

    // Builds the stored corners of a default-oriented slab from its near and far corners.
    function automatic corners_t make_slab(
        input coord_t nx,
        input coord_t ny,
        input coord_t nz,
        input coord_t fx,
        input coord_t fy,
        input coord_t fz
    );
        corners_t c;
        c.first  = {nz, ny, nx};
        c.second = {BYTE_MAX - fz, BYTE_MAX - fy, BYTE_MAX - fx};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/bss_item_if.sv
// Request channel carrying one pair of encoded boxes.
`default_nettype none

interface bss_item_if;
    logic        valid;
    logic        ready;
    logic [23:0] outer_first_corner;
    logic [23:0] outer_second_corner;
    logic [15:0] outer_material;
    logic [23:0] inner_first_corner;
    logic [23:0] inner_second_corner;
    logic [15:0] inner_material;

    modport source (
        output valid,
        output outer_first_corner,
        output outer_second_corner,
        output outer_material,
        output inner_first_corner,
        output inner_second_corner,
        output inner_material,
        input  ready
    );

    modport sink (
        input  valid,
        input  outer_first_corner,
        input  outer_second_corner,
        input  outer_material,
        input  inner_first_corner,
        input  inner_second_corner,
        input  inner_material,
        output ready
    );
endinterface

`default_nettype wire

>>> design/bss_piece_if.sv
// Request channel carrying one result box of a split.
`default_nettype none

interface bss_piece_if;
    logic        valid;
    logic        ready;
    logic [2:0]  piece_kind;
    logic [23:0] piece_first_corner;
    logic [23:0] piece_second_corner;
    logic [15:0] piece_material;
    logic        last_piece;

    modport source (
        output valid,
        output piece_kind,
        output piece_first_corner,
        output piece_second_corner,
        output piece_material,
        output last_piece,
        input  ready
    );

    modport sink (
        input  valid,
        input  piece_kind,
        input  piece_first_corner,
        input  piece_second_corner,
        input  piece_material,
        input  last_piece,
        output ready
    );
endinterface

`default_nettype wire

>>> design/bss_decode.sv
// Decodes a stored box into per-axis minimum and maximum coordinates.
`default_nettype none

module bss_decode
    import bss_pkg::*;
(
    input  wire logic [23:0] first,
    input  wire logic [23:0] second,
    output bounds_t          bounds
);

    always_comb
    begin
        coord_t p;
        coord_t q;
        for (int a = 0; a < 3; a++)
        begin
            p = first[8*a +: 8];
            q = BYTE_MAX - second[8*a +: 8];
            if (p < q)
            begin
                bounds.lo[a] = p;
                bounds.hi[a] = q;
            end
            else
            begin
                bounds.lo[a] = q;
                bounds.hi[a] = p;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/box_subtract_split_core.sv
// Top level of the box subtract split block: splits an outer box around an inner box.
//
// Usage: a request on the item channel carries two encoded boxes (outer and
// inner). For each request the block sends, on the piece channel, up to six
// slabs of the outer material (left, below, behind, right, above, front, in
// that order, each only where its bounds differ) and then the inner box
// unchanged with last_piece set.
// The request is decoded into the work register when it is accepted; its pieces
// then move in turn to the piece register, which drives the piece channel.
// Throughput: one piece per cycle unless the receiver stalls; a request gives
// one to seven pieces, by how many slabs it yields. The work register releases
// the request on the cycle its final piece moves to the piece register, so
// the next request is taken in that same cycle and pieces flow without gaps.
// Reset clears the work register's pending mask and the piece valid flag;
// no payload is cleared. When the receiver stalls, the piece register holds
// its contents; the work register takes at most one more request and then
// waits, so the item channel stalls as well.
`default_nettype none

module box_subtract_split_core
    import bss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bss_item_if.sink   item,
    bss_piece_if.source piece
);

    // Decoded view of the incoming request.
    bounds_t outer_dec;
    bounds_t inner_dec;

    bss_decode u_outer_decode (
        .first  (item.outer_first_corner),
        .second (item.outer_second_corner),
        .bounds (outer_dec)
    );

    bss_decode u_inner_decode (
        .first  (item.inner_first_corner),
        .second (item.inner_second_corner),
        .bounds (inner_dec)
    );

    // Work register: one request with a mask of the pieces still to send.
    bounds_t                 ob_reg;
    bounds_t                 ib_reg;
    logic [23:0]             inner_first_reg;
    logic [23:0]             inner_second_reg;
    logic [15:0]             omat_reg;
    logic [15:0]             imat_reg;
    logic [NUM_KINDS-1:0]    pend_reg;
    logic [NUM_KINDS-1:0]    pend_next;

    // Piece register feeding the output channel.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    piece_kind_t             kind_reg;
    logic [23:0]             first_reg;
    logic [23:0]             second_reg;
    logic [15:0]             mat_reg;
    logic                    last_reg;

    logic                    load_en;
    logic                    fire;
    logic                    accept;
    logic [NUM_KINDS-1:0]    pick;
    logic [NUM_KINDS-1:0]    pend_left;
    logic [NUM_KINDS-1:0]    new_mask;
    piece_kind_t             kind_sel;
    corners_t                corners_sel;
    logic [15:0]             mat_sel;
    logic                    last_sel;

    // The piece register can take a new piece when it is empty or being drained.
    assign load_en   = !out_valid_reg || piece.ready;
    assign pick      = pend_reg & (~pend_reg + NUM_KINDS'(1));
    assign fire      = load_en && (pend_reg != '0);
    assign pend_left = pend_reg & ~pick;

    // A new request enters when the work register is free or frees up now.
    assign item.ready = (pend_reg == '0) || (fire && (pend_left == '0));
    assign accept     = item.valid && item.ready;

    // One bit per piece kind; the inner remainder is always sent.
    assign new_mask = {
        1'b1,
        inner_dec.hi[2] != outer_dec.hi[2],
        inner_dec.hi[1] != outer_dec.hi[1],
        inner_dec.hi[0] != outer_dec.hi[0],
        outer_dec.lo[2] != inner_dec.lo[2],
        outer_dec.lo[1] != inner_dec.lo[1],
        outer_dec.lo[0] != inner_dec.lo[0]
    };

    always_comb
    begin
        if (accept)
        begin
            pend_next = new_mask;
        end
        else if (fire)
        begin
            pend_next = pend_left;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    // Turn the lowest pending bit into a piece kind.
    always_comb
    begin
        case (pick)
            7'b0000001: kind_sel = KIND_LEFT;
            7'b0000010: kind_sel = KIND_BELOW;
            7'b0000100: kind_sel = KIND_BEHIND;
            7'b0001000: kind_sel = KIND_RIGHT;
            7'b0010000: kind_sel = KIND_ABOVE;
            7'b0100000: kind_sel = KIND_FRONT;
            default:    kind_sel = KIND_INNER;
        endcase
    end

    // Corners of the selected piece. Slabs are built from near and far
    // corners; the inner remainder keeps its stored corners as given.
    always_comb
    begin
        mat_sel  = omat_reg;
        last_sel = 1'b0;
        case (kind_sel)
            KIND_LEFT:
                corners_sel = make_slab(ob_reg.lo[0], ob_reg.lo[1], ob_reg.lo[2],
                                        ib_reg.lo[0], ob_reg.hi[1], ob_reg.hi[2]);
            KIND_BELOW:
                corners_sel = make_slab(ib_reg.lo[0], ob_reg.lo[1], ob_reg.lo[2],
                                        ib_reg.hi[0], ib_reg.lo[1], ob_reg.hi[2]);
            KIND_BEHIND:
                corners_sel = make_slab(ib_reg.lo[0], ib_reg.lo[1], ob_reg.lo[2],
                                        ib_reg.hi[0], ib_reg.hi[1], ib_reg.lo[2]);
            KIND_RIGHT:
                corners_sel = make_slab(ib_reg.hi[0], ob_reg.lo[1], ob_reg.lo[2],
                                        ob_reg.hi[0], ob_reg.hi[1], ob_reg.hi[2]);
            KIND_ABOVE:
                corners_sel = make_slab(ib_reg.lo[0], ib_reg.hi[1], ob_reg.lo[2],
                                        ib_reg.hi[0], ob_reg.hi[1], ob_reg.hi[2]);
            KIND_FRONT:
                corners_sel = make_slab(ib_reg.lo[0], ib_reg.lo[1], ib_reg.hi[2],
                                        ib_reg.hi[0], ib_reg.hi[1], ob_reg.hi[2]);
            default:
            begin
                corners_sel.first  = inner_first_reg;
                corners_sel.second = inner_second_reg;
                mat_sel            = imat_reg;
                last_sel           = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (load_en)
        begin
            out_valid_next = fire;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Work register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ob_reg           <= outer_dec;
            ib_reg           <= inner_dec;
            inner_first_reg  <= item.inner_first_corner;
            inner_second_reg <= item.inner_second_corner;
            omat_reg         <= item.outer_material;
            imat_reg         <= item.inner_material;
        end
    end

    // Piece register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg   <= kind_sel;
            first_reg  <= corners_sel.first;
            second_reg <= corners_sel.second;
            mat_reg    <= mat_sel;
            last_reg   <= last_sel;
        end
    end

    assign piece.valid               = out_valid_reg;
    assign piece.piece_kind          = kind_reg;
    assign piece.piece_first_corner  = first_reg;
    assign piece.piece_second_corner = second_reg;
    assign piece.piece_material      = mat_reg;
    assign piece.last_piece          = last_reg;

endmodule

`default_nettype wire
